// ===== rtl/whb_pkg.sv =====
// Shared types and constants of the weighted histogram binner.
// No dependencies; every other file of the block imports it.
package whb_pkg;

    localparam int POS_W   = 32;  // position and range edges
    localparam int WT_W    = 32;  // sample weight
    localparam int SUM_W   = 48;  // saturating bin sum
    localparam int CNT_W   = 32;  // accepted-event counter
    localparam int CHAN_W  = 9;   // channel count register
    localparam int IDX_W   = 8;   // bin index on the ports
    localparam int QUOT_W  = 9;   // bin quotient, always below the channel count
    localparam int PROD_W  = CHAN_W + POS_W;  // channels * offset
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 2'd2;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_RDREQ,
        ST_UPDATE,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/whb_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the bin number.
// Depends on whb_pkg; the quotient must be known to fit in QUOT_W bits.
module whb_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [whb_pkg::PROD_W-1:0]  i_num,
    input  logic [whb_pkg::POS_W-1:0]   i_den,
    output logic                        o_done,
    output logic [whb_pkg::QUOT_W-1:0]  o_quot
);
    import whb_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic [POS_W-1:0]  r_rem,  n_rem;
    logic [QUOT_W-1:0] r_lo,   n_lo;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [POS_W:0]    w_trial;
    logic [POS_W:0]    w_diff;
    logic              w_fit;

    assign w_trial = {r_rem, r_lo[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_fit   = (w_trial >= {1'b0, i_den});

    always_comb begin
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quot = r_quot;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // top bits are already below the divisor
            n_rem  = i_num[PROD_W-1:QUOT_W];
            n_lo   = i_num[QUOT_W-1:0];
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_fit ? w_diff[POS_W-1:0] : w_trial[POS_W-1:0];
            n_lo   = {r_lo[QUOT_W-2:0], 1'b0};
            n_quot = {r_quot[QUOT_W-2:0], w_fit};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/whb_store.sv =====
// Bin sum memory: one write port, one read port with registered data.
// Depends on whb_pkg for the sum width.
module whb_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [whb_pkg::SUM_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [whb_pkg::SUM_W-1:0]  o_rdata
);
    import whb_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/weighted_histogram_binner_top.sv =====
// Weighted 1-D histogram: sequencer, config registers, bin update and result register.
// Depends on whb_pkg, whb_divider and whb_store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | i_valid / o_ready    | i_cmd, i_position, i_weight, i_read_bin
//  result   | o_valid / i_ready    | o_accepted, o_bin_index, o_bin_sum, o_event_total
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// One transaction at a time. An in-range accumulate goes through prepare, multiply, divider start,
// the 9-step serial divider, memory read, write-back and result load. A read goes through memory
// read, update and result load, and an out-of-range sample through prepare and result load.
// o_ready returns the cycle after the result loads, so a new item waits until the last result has loaded.
// After reset the bin memory is cleared one entry a cycle, with o_ready low.
// A finished result waits in the output register; a stalled output only holds the last state.
module weighted_histogram_binner_top #(
    parameter int NUM_BINS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [whb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [whb_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic signed [whb_pkg::POS_W-1:0]  i_position,
    input  logic signed [whb_pkg::WT_W-1:0]   i_weight,
    input  logic [whb_pkg::IDX_W-1:0]         i_read_bin,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_accepted,
    output logic [whb_pkg::IDX_W-1:0]         o_bin_index,
    output logic signed [whb_pkg::SUM_W-1:0]  o_bin_sum,
    output logic [whb_pkg::CNT_W-1:0]         o_event_total
);
    import whb_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);

    t_state r_state, n_state;

    logic signed [POS_W-1:0] r_range_low, r_range_high;
    logic [CHAN_W-1:0]       r_chan_count;

    logic                    r_cmd;
    logic signed [POS_W-1:0] r_pos;
    logic signed [WT_W-1:0]  r_wt;
    logic [IDX_W-1:0]        r_rbin;
    logic [BIN_W-1:0]        r_addr;
    logic [BIN_W-1:0]        r_clr_addr;
    logic [POS_W-1:0]        r_off, r_span;
    logic [CHAN_W-1:0]       r_chans;
    logic [PROD_W-1:0]       r_prod;
    logic [CNT_W-1:0]        r_event_cnt;

    logic                    r_res_accepted;
    logic [IDX_W-1:0]        r_res_idx;
    logic [SUM_W-1:0]        r_res_sum;

    logic                    r_out_valid;

    logic                    w_accept;
    logic                    w_hit;
    logic signed [POS_W:0]   w_off, w_span;
    logic [CHAN_W-1:0]       w_chans;
    logic                    w_div_start, w_div_done;
    logic [QUOT_W-1:0]       w_quot;
    logic [BIN_W-1:0]        w_bin;
    logic                    w_we;
    logic [BIN_W-1:0]        w_waddr;
    logic [SUM_W-1:0]        w_wdata;
    logic [SUM_W-1:0]        w_rdata;
    logic signed [SUM_W:0]   w_sum_wide;
    logic [SUM_W-1:0]        w_sum_sat;
    logic                    w_load_out;

    // ---------------- config registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= {1'b0, {(POS_W-1){1'b1}}};
            r_chan_count <= CHAN_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_wdata[POS_W-1:0];
                CFG_RANGE_HIGH: r_range_high <= i_cfg_wdata[POS_W-1:0];
                CFG_CHAN_COUNT: r_chan_count <= i_cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- combinational datapath ----------------
    assign w_accept = i_valid && o_ready;
    assign w_hit    = (r_pos >= r_range_low) && (r_pos < r_range_high);
    assign w_off    = {r_pos[POS_W-1], r_pos} - {r_range_low[POS_W-1], r_range_low};
    assign w_span   = {r_range_high[POS_W-1], r_range_high}
                    - {r_range_low[POS_W-1], r_range_low};

    always_comb begin
        w_chans = r_chan_count;
        if (r_chan_count == '0) begin
            w_chans = CHAN_W'(1);
        end else if (32'(r_chan_count) > NUM_BINS) begin
            w_chans = CHAN_W'(NUM_BINS);
        end
    end

    always_comb begin
        if (32'(w_quot) > NUM_BINS - 1) begin
            w_bin = BIN_W'(NUM_BINS - 1);
        end else begin
            w_bin = BIN_W'(w_quot);
        end
    end

    assign w_sum_wide = $signed({w_rdata[SUM_W-1], w_rdata})
                      + $signed({{(SUM_W+1-WT_W){r_wt[WT_W-1]}}, r_wt});

    always_comb begin
        if (w_sum_wide[SUM_W] != w_sum_wide[SUM_W-1]) begin
            w_sum_sat = w_sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_sat = w_sum_wide[SUM_W-1:0];
        end
    end

    assign w_load_out = !r_out_valid || i_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = w_sum_sat;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == BIN_W'(NUM_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd == CMD_READ) ? ST_RDREQ : ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = w_hit ? ST_MUL : ST_FINISH;
            end
            ST_MUL: begin
                n_state = ST_DSTART;
            end
            ST_DSTART: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_RDREQ;
                end
            end
            ST_RDREQ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                w_we    = (r_cmd == CMD_ACCUM);
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_pos  <= i_position;
            r_wt   <= i_weight;
            r_rbin <= i_read_bin;
            r_addr <= BIN_W'(i_read_bin);
        end
        if (r_state == ST_PREP) begin
            r_off          <= w_off[POS_W-1:0];
            r_span         <= w_span[POS_W-1:0];
            r_chans        <= w_chans;
            // rejected sample reports zeros
            r_res_accepted <= 1'b0;
            r_res_idx      <= '0;
            r_res_sum      <= '0;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_chans) * PROD_W'(r_off);
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_addr <= w_bin;
        end
        if (r_state == ST_UPDATE) begin
            if (r_cmd == CMD_READ) begin
                r_res_accepted <= 1'b0;
                r_res_idx      <= r_rbin;
                r_res_sum      <= (32'(r_rbin) < NUM_BINS) ? w_rdata : '0;
            end else begin
                r_res_accepted <= 1'b1;
                r_res_idx      <= IDX_W'(r_addr);
                r_res_sum      <= w_sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_cnt <= '0;
        end else if (r_state == ST_UPDATE && r_cmd == CMD_ACCUM && r_event_cnt != CNT_MAX) begin
            r_event_cnt <= r_event_cnt + 1'b1;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && w_load_out) begin
            o_accepted    <= r_res_accepted;
            o_bin_index   <= r_res_idx;
            o_bin_sum     <= r_res_sum;
            o_event_total <= r_event_cnt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ready = (r_state == ST_IDLE);

    // ---------------- submodules ----------------
    whb_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    whb_store #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // ---------------- assertions ----------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_event_cnt >= $past(r_event_cnt)))
        else $error("event counter went backwards");

    a_cnt_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPDATE) |=> $stable(r_event_cnt))
        else $error("event counter changed outside a bin update");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FINISH) |-> !w_we)
        else $error("bin memory written while no transaction is in work");

endmodule

// ===== tb/sv/tb_weighted_histogram_binner_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for weighted_histogram_binner_top: directed, large-weight and random runs.
// Depends on whb_pkg and the block's RTL. An in-bench predictor tracks bin sums and the event count.
module tb_weighted_histogram_binner_top;
    import whb_pkg::*;

    localparam int BINS           = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HEAVY_SAMPLES  = 24;

    typedef struct packed {
        logic                    accepted;
        logic [IDX_W-1:0]        bin_index;
        logic signed [SUM_W-1:0] bin_sum;
        logic [CNT_W-1:0]        event_total;
    } t_bin_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_cmd;
    logic signed [POS_W-1:0] i_position;
    logic signed [WT_W-1:0]  i_weight;
    logic [IDX_W-1:0]        i_read_bin;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_accepted;
    logic [IDX_W-1:0]        o_bin_index;
    logic signed [SUM_W-1:0] o_bin_sum;
    logic [CNT_W-1:0]        o_event_total;

    // Predictor state: bins, counter and the register copies
    longint                  bin_sums [BINS];
    logic [CNT_W-1:0]        event_count;
    logic signed [POS_W-1:0] cfg_low;
    logic signed [POS_W-1:0] cfg_high;
    logic [CHAN_W-1:0]       cfg_chans;

    t_bin_result expected_bins[$];
    int          err_cnt       = 0;
    int          n_results     = 0;
    int          n_hits        = 0;
    int          n_settings    = 0;
    int          quiet_cycles  = 0;
    int          sink_hold_len = 0;
    bit          idle_on;

    weighted_histogram_binner_top #(
        .NUM_BINS (BINS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_weight      (i_weight),
        .i_read_bin    (i_read_bin),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_accepted    (o_accepted),
        .o_bin_index   (o_bin_index),
        .o_bin_sum     (o_bin_sum),
        .o_event_total (o_event_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one transaction to the predicted histogram and return its result
    function automatic t_bin_result histogram_step(input logic cmd,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [WT_W-1:0] wt,
                                                   input logic [IDX_W-1:0] rbin);
        t_bin_result r;
        longint      span;
        longint      offset;
        longint      chans;
        longint      slot;
        longint      acc;
        r = '0;
        r.event_total = event_count;
        if (cmd == CMD_READ) begin
            r.bin_index = rbin;
            if (rbin < BINS)
                r.bin_sum = bin_sums[rbin][SUM_W-1:0];
            return r;
        end
        if (pos >= cfg_low && pos < cfg_high) begin
            span   = longint'(cfg_high) - longint'(cfg_low);
            offset = longint'(pos) - longint'(cfg_low);
            chans  = (cfg_chans == 0) ? 1 : ((cfg_chans > BINS) ? BINS : cfg_chans);
            slot   = (chans * offset) / span;
            if (slot >= BINS)
                slot = BINS - 1;
            acc = bin_sums[slot] + longint'(wt);
            if (acc > longint'(SUM_MAX))
                acc = longint'(SUM_MAX);
            if (acc < longint'(SUM_MIN))
                acc = longint'(SUM_MIN);
            bin_sums[slot] = acc;
            if (event_count != CNT_MAX)
                event_count = event_count + 1'b1;
            r.accepted    = 1'b1;
            r.bin_index   = slot[IDX_W-1:0];
            r.bin_sum     = acc[SUM_W-1:0];
            r.event_total = event_count;
        end
        return r;
    endfunction

    // Offer one transaction; valid is left high so back-to-back items need no gap
    task automatic send_item(input logic cmd, input logic signed [POS_W-1:0] pos,
                             input logic signed [WT_W-1:0] wt, input logic [IDX_W-1:0] rbin);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_weight   <= wt;
        i_read_bin <= rbin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_bins.push_back(histogram_step(cmd, pos, wt, rbin));
    endtask

    // Hold the input until every pending result is back and the block has gone idle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_RANGE_LOW:  cfg_low   = val;
            CFG_RANGE_HIGH: cfg_high  = val;
            CFG_CHAN_COUNT: cfg_chans = val[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_range(input logic signed [POS_W-1:0] lo, input logic signed [POS_W-1:0] hi,
                             input logic [CHAN_W-1:0] chans);
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
        write_reg(CFG_CHAN_COUNT, CFG_W'(chans));
        n_settings++;
    endtask

    // Mostly in-range samples with random content, plus reads, edge hits and stray positions
    task automatic send_random(input int count);
        logic signed [POS_W-1:0] pos;
        logic signed [WT_W-1:0]  wt;
        logic [IDX_W-1:0]        rbin;
        longint                  span;
        int                      pick;
        for (int k = 0; k < count; k++) begin
            pos  = $urandom;
            wt   = $urandom;
            rbin = IDX_W'($urandom);
            span = longint'(cfg_high) - longint'(cfg_low);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: wt = 32'sh7FFF_FFFF;
                    1: wt = 32'sh8000_0000;
                    2: wt = '0;
                    default: wt = -1;
                endcase
            end
            if (pick < 25) begin
                send_item(CMD_READ, pos, wt, rbin);
            end else begin
                if (pick < 85 && span > 0) begin
                    pos = cfg_low + 32'({$urandom, $urandom} % span);
                end else if (pick < 95) begin
                    case ($urandom_range(0, 3))
                        0: pos = cfg_low;
                        1: pos = cfg_high - 1;
                        2: pos = cfg_high;
                        default: pos = cfg_low - 1;
                    endcase
                end
                send_item(CMD_ACCUM, pos, wt, rbin);
            end
        end
    endtask

    task automatic test_directed();
        send_item(CMD_READ, 0, 0, 8'd0);
        send_item(CMD_READ, -1, -1, 8'd255);
        send_item(CMD_ACCUM, 0, 32'sh7FFF_FFFF, 8'd0);
        send_item(CMD_ACCUM, 32'sh7FFF_FFFE, 32'sh8000_0000, 8'd0);
        send_item(CMD_ACCUM, 32'sh7FFF_FFFF, 5, 8'd0);   // upper edge is exclusive
        send_item(CMD_ACCUM, -1, 5, 8'd0);
        send_item(CMD_ACCUM, 32'sh8000_0000, 5, 8'd0);
        send_item(CMD_READ, 0, 0, 8'd0);
        send_item(CMD_READ, 0, 0, 8'd255);
        // count above the bin total acts as the full store
        set_range(32'sh8000_0000, 32'sh7FFF_FFFF, 9'd511);
        send_item(CMD_ACCUM, 32'sh8000_0000, 1, 8'd0);
        send_item(CMD_ACCUM, 32'sh7FFF_FFFE, -1, 8'd0);
        send_item(CMD_ACCUM, 0, 5, 8'd0);
        set_range(7, 7, 9'd3);
        send_item(CMD_ACCUM, 7, 9, 8'd0);
        set_range(10, -10, 9'd1);
        send_item(CMD_ACCUM, 0, 9, 8'd0);
        // zero channels behaves as a single bin
        set_range(-100, 100, 9'd0);
        send_item(CMD_ACCUM, 99, 3, 8'd0);
        send_item(CMD_ACCUM, -100, 4, 8'd0);
        send_item(CMD_ACCUM, 100, 4, 8'd0);
        set_range(0, 3, 9'd257);
        send_item(CMD_ACCUM, 2, 11, 8'd0);
        send_item(CMD_READ, $urandom, $urandom, 8'd170);
    endtask

    // Pile maximum weights onto one bin back to back, then pull it down with minimum weights
    task automatic test_large_weights();
        idle_on = 1'b0;
        set_range(0, 1, 9'd1);
        for (int k = 0; k < HEAVY_SAMPLES; k++)
            send_item(CMD_ACCUM, 0, 32'sh7FFF_FFFF, 8'd0);
        send_item(CMD_READ, 0, 0, 8'd0);
        for (int k = 0; k < 4; k++)
            send_item(CMD_ACCUM, 0, 32'sh8000_0000, 8'd0);
        idle_on = 1'b1;
    endtask

    task automatic test_random_settings();
        logic signed [POS_W-1:0] lo;
        set_range(32'sh8000_0000, 32'sh7FFF_FFFF, 9'd256);
        send_random(150);
        set_range(-1000, 1000, 9'd7);
        send_random(150);
        set_range(32'sh8000_0000, 32'sh8000_0001, 9'd511);
        send_random(100);
        set_range(5, 5, 9'd3);
        send_random(50);
        for (int k = 0; k < 3; k++) begin
            lo = $urandom;
            set_range(lo, lo + $urandom_range(1, 100000), CHAN_W'($urandom_range(0, 511)));
            send_random(120);
        end
    endtask

    // Stall the result side long enough to back up the input, then let the sender run dry
    task automatic test_backpressure();
        set_range(-5000, 5000, 9'd64);
        sink_hold_len = 200;
        send_random(12);
        drain_results();
        send_random(30);
    endtask

    task automatic test_final_burst();
        idle_on = 1'b0;
        set_range(-50000, 50000, 9'd256);
        send_random(200);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_cmd       = CMD_ACCUM;
        i_position  = '0;
        i_weight    = '0;
        i_read_bin  = '0;
        idle_on     = 1'b1;
        for (int k = 0; k < BINS; k++)
            bin_sums[k] = 0;
        event_count = '0;
        cfg_low     = '0;
        cfg_high    = 32'sh7FFF_FFFF;
        cfg_chans   = 9'd256;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_settings();
        test_backpressure();
        test_large_weights();
        test_final_burst();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results (%0d binned samples) over %0d range settings,",
                 n_results, n_hits, n_settings);
        $display("including extreme weights, empty ranges and a long result stall.");
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : result_sink
        int hold;
        hold    = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_len > 0) begin
                hold          = sink_hold_len;
                sink_hold_len = 0;
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_bin_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_bins.size() == 0) begin
                $error("result with no transaction pending: bin_index %0d bin_sum %0d",
                       o_bin_index, o_bin_sum);
                err_cnt++;
            end else begin
                exp_r = expected_bins.pop_front();
                if (exp_r.accepted)
                    n_hits++;
                if (o_accepted !== exp_r.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_r.accepted, o_accepted);
                    err_cnt++;
                end
                if (o_bin_index !== exp_r.bin_index) begin
                    $error("bin_index: expected %0d, got %0d", exp_r.bin_index, o_bin_index);
                    err_cnt++;
                end
                if (o_bin_sum !== exp_r.bin_sum) begin
                    $error("bin_sum: expected %0d, got %0d", exp_r.bin_sum, o_bin_sum);
                    err_cnt++;
                end
                if (o_event_total !== exp_r.event_total) begin
                    $error("event_total: expected %0d, got %0d", exp_r.event_total,
                           o_event_total);
                    err_cnt++;
                end
            end
        end
    end

    // Abort when neither channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== weighted_histogram_binner_top.f =====
rtl/whb_pkg.sv
rtl/whb_divider.sv
rtl/whb_store.sv
rtl/weighted_histogram_binner_top.sv
tb/sv/tb_weighted_histogram_binner_top.sv
